FILE: src/lgb_pkg.sv
// Shared types, constants and arithmetic helpers of the 2D Legendre basis row generator.
package lgb_pkg;

    localparam int MAX_ORDER = 4;
    localparam int IDX_W     = $clog2(MAX_ORDER + 1);
    localparam int POS_W     = 16;
    localparam int VAL_W     = 20;
    localparam int ORD_W     = 3;
    localparam int TERM_W    = 4;
    localparam int QBITS     = 19;
    localparam int X_W       = 24;
    localparam int RECIP_S   = 28;
    localparam int RECIP_N   = 10;
    localparam int RECIP_IW  = $clog2(RECIP_N);
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic [RECIP_S-1:0] t_recip;

    localparam t_val VAL_MAX = 20'sh7FFFF;
    localparam t_val VAL_MIN = 20'sh80000;
    localparam t_val ONE_Q16 = 20'sh10000;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_FIT_ORDER = 3'd0;
    localparam logic [2:0] REG_X_LOW     = 3'd1;
    localparam logic [2:0] REG_X_HIGH    = 3'd2;
    localparam logic [2:0] REG_Y_LOW     = 3'd3;
    localparam logic [2:0] REG_Y_HIGH    = 3'd4;

    // Rounded-up reciprocals; for i of 2 and up, floor(x * RECIP[i] / 2^28) equals floor(x / i) for x below 2^24.
    localparam t_recip RECIP [0:RECIP_N-1] = '{
        t_recip'(0),
        t_recip'(0),
        t_recip'(((2**RECIP_S) + 2 - 1) / 2),
        t_recip'(((2**RECIP_S) + 3 - 1) / 3),
        t_recip'(((2**RECIP_S) + 4 - 1) / 4),
        t_recip'(((2**RECIP_S) + 5 - 1) / 5),
        t_recip'(((2**RECIP_S) + 6 - 1) / 6),
        t_recip'(((2**RECIP_S) + 7 - 1) / 7),
        t_recip'(((2**RECIP_S) + 8 - 1) / 8),
        t_recip'(((2**RECIP_S) + 9 - 1) / 9)
    };

    // One coordinate on its way through the restoring divider.
    typedef struct packed {
        logic             valid;
        logic             neg;
        logic             sat;
        logic             zero;
        logic [POS_W-1:0] divisor;
        logic [POS_W-1:0] rem;
        logic [QBITS-1:0] dq;
    } t_div;

    // One coordinate on its way through the recurrence.
    typedef struct packed {
        logic                 valid;
        t_val                 u;
        t_val [MAX_ORDER:0]   vals;
    } t_rec;

    // Applies a sign to a rounded magnitude and saturates to Q3.16.
    function automatic t_val f_sat_mag(logic neg, logic big, logic [VAL_W-1:0] mag);
        t_val res;
        if (neg) begin
            if (big || (mag > 20'h80000)) res = VAL_MIN;
            else res = t_val'(~mag + 1'b1);
        end else begin
            if (big || mag[VAL_W-1]) res = VAL_MAX;
            else res = t_val'(mag);
        end
        return res;
    endfunction

    // Sets up the division (2*pos - lo - hi) * 2^16 / (hi - lo) with rounding offset.
    function automatic t_div f_div_init(logic [POS_W-1:0] pos, logic [POS_W-1:0] lo,
                                        logic [POS_W-1:0] hi);
        logic signed [POS_W+1:0] num;
        logic [POS_W:0]          absn;
        logic [2*POS_W:0]        dvd;
        t_div                    d;
        num = $signed({1'b0, pos, 1'b0}) - $signed({2'b00, lo}) - $signed({2'b00, hi});
        absn = num[POS_W+1] ? (POS_W+1)'(-num) : num[POS_W:0];
        d.valid = 1'b0;
        d.zero = (hi <= lo);
        d.neg = num[POS_W+1];
        d.divisor = hi - lo;
        d.sat = ({2'b00, absn} >= {d.divisor, 3'b000});
        dvd = {absn, 16'h0000} + (2*POS_W+1)'(d.divisor >> 1);
        d.rem = POS_W'(dvd[2*POS_W:QBITS]);
        d.dq = dvd[QBITS-1:0];
        return d;
    endfunction

    // Turns a finished quotient into the normalized coordinate.
    function automatic t_val f_div_done(t_div d);
        t_val res;
        if (d.zero) res = '0;
        else res = f_sat_mag(d.neg, d.sat, {1'b0, d.dq});
        return res;
    endfunction

endpackage

FILE: src/legendre_2d_basis_row_top.sv
// The output serializer emits one word per cycle while i_stall is low and positions keep
// coming; a position yields (order+1)(order+2)/2 words, 15 at order 4. The divider and
// recurrence cell rows take a new position whenever the pipeline advances, so the serializer
// sets the pace. Reset is synchronous and active low; it empties the pipeline and the output
// register and loads fit_order 2, low bounds 0 and high bounds 65535.
module legendre_2d_basis_row_top import lgb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [POS_W-1:0]     i_pos_x,
    input  logic [POS_W-1:0]     i_pos_y,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [TERM_W-1:0]    o_term_index,
    output logic signed [VAL_W-1:0] o_term_value,
    output logic                 o_last_term
);

    // Configuration registers.
    logic [ORD_W-1:0] r_fit_order;
    logic [POS_W-1:0] r_x_low;
    logic [POS_W-1:0] r_x_high;
    logic [POS_W-1:0] r_y_low;
    logic [POS_W-1:0] r_y_high;
    logic [2:0]       reg_idx;
    logic             cfg_wr;
    logic [IDX_W-1:0] ord;
    logic [TERM_W-1:0] last_idx;

    assign pready = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_order <= ORD_W'(2);
            r_x_low <= '0;
            r_x_high <= '1;
            r_y_low <= '0;
            r_y_high <= '1;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_FIT_ORDER: r_fit_order <= pwdata[ORD_W-1:0];
                REG_X_LOW:     r_x_low <= pwdata[POS_W-1:0];
                REG_X_HIGH:    r_x_high <= pwdata[POS_W-1:0];
                REG_Y_LOW:     r_y_low <= pwdata[POS_W-1:0];
                REG_Y_HIGH:    r_y_high <= pwdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FIT_ORDER: prdata = DATA_W'(r_fit_order);
            REG_X_LOW:     prdata = DATA_W'(r_x_low);
            REG_X_HIGH:    prdata = DATA_W'(r_x_high);
            REG_Y_LOW:     prdata = DATA_W'(r_y_low);
            REG_Y_HIGH:    prdata = DATA_W'(r_y_high);
            default:       prdata = '0;
        endcase
    end

    // An order above what the recurrence row was built for runs at the built maximum.
    assign ord = (32'(r_fit_order) > MAX_ORDER) ? IDX_W'(MAX_ORDER) : IDX_W'(r_fit_order);
    assign last_idx = TERM_W'(((32'(ord) + 1) * (32'(ord) + 2)) / 2 - 1);

    // The whole pipeline moves as one: it advances whenever its last stage is empty or the
    // serializer takes that stage's position in this cycle.
    t_div w_dx [0:QBITS];
    t_div w_dy [0:QBITS];
    t_rec w_rx [0:MAX_ORDER-1];
    t_rec w_ry [0:MAX_ORDER-1];
    t_div r_sa_x;
    t_div r_sa_y;
    t_div n_sa_x;
    t_div n_sa_y;
    logic adv;
    logic take;

    assign adv = !w_rx[MAX_ORDER-1].valid || take;
    assign o_stall = !adv;

    // Entry stage: numerator, span, overflow check and rounding offset for both coordinates.
    always_comb begin
        n_sa_x = f_div_init(i_pos_x, r_x_low, r_x_high);
        n_sa_y = f_div_init(i_pos_y, r_y_low, r_y_high);
        n_sa_x.valid = i_valid;
        n_sa_y.valid = i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sa_x.valid <= 1'b0;
            r_sa_y.valid <= 1'b0;
        end else if (adv) begin
            r_sa_x <= n_sa_x;
            r_sa_y <= n_sa_y;
        end
    end

    assign w_dx[0] = r_sa_x;
    assign w_dy[0] = r_sa_y;

    // One quotient bit per cell; the chain yields the full 19-bit rounded quotient.
    for (genvar g = 0; g < QBITS; g++) begin : g_div
        lgb_div_cell u_div_x (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_d     (w_dx[g]),
            .o_d     (w_dx[g+1])
        );
        lgb_div_cell u_div_y (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_d     (w_dy[g]),
            .o_d     (w_dy[g+1])
        );
    end

    // P0 is one and P1 is the normalized coordinate itself.
    always_comb begin
        w_rx[0] = '0;
        w_rx[0].valid = w_dx[QBITS].valid;
        w_rx[0].u = f_div_done(w_dx[QBITS]);
        w_rx[0].vals[0] = ONE_Q16;
        w_rx[0].vals[1] = w_rx[0].u;
        w_ry[0] = '0;
        w_ry[0].valid = w_dy[QBITS].valid;
        w_ry[0].u = f_div_done(w_dy[QBITS]);
        w_ry[0].vals[0] = ONE_Q16;
        w_ry[0].vals[1] = w_ry[0].u;
    end

    // Cell j computes P[j+2] from P[j+1] and P[j].
    for (genvar j = 0; j < MAX_ORDER - 1; j++) begin : g_rec
        lgb_rec_cell u_rec_x (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_idx   (IDX_W'(j + 2)),
            .i_r     (w_rx[j]),
            .o_r     (w_rx[j+1])
        );
        lgb_rec_cell u_rec_y (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_idx   (IDX_W'(j + 2)),
            .i_r     (w_ry[j]),
            .o_r     (w_ry[j+1])
        );
    end

    // The serializer loads a new position in the cycle its previous row's last word leaves,
    // so rows follow each other without a gap.
    lgb_term_gen u_term (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (w_rx[MAX_ORDER-1].valid),
        .i_px         (w_rx[MAX_ORDER-1].vals),
        .i_py         (w_ry[MAX_ORDER-1].vals),
        .i_order      (ord),
        .i_stall      (i_stall),
        .o_take       (take),
        .o_valid      (o_valid),
        .o_index      (o_term_index),
        .o_value      (o_term_value),
        .o_last       (o_last_term)
    );

    // The final word of a row carries the last dense index for the configured order.
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_term) |-> (o_term_index == last_idx))
        else $error("last word of a row has the wrong index");

    // Within a row the words leave back to back with consecutive indexes.
    a_row_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_term) |=>
        (o_valid && (o_term_index == $past(o_term_index) + TERM_W'(1))))
        else $error("row words are not consecutive");

    // A new row always begins at index zero.
    a_row_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last_term) |=> (!o_valid || (o_term_index == '0)))
        else $error("row does not start at index zero");

    // The pipeline never takes a position while its last stage holds one that stays.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rx[MAX_ORDER-1].valid && !take) |-> o_stall)
        else $error("pipeline advanced over an unconsumed position");

endmodule

FILE: src/lgb_div_cell.sv
// One restoring division step: a cell of the normalizing divider chain.
module lgb_div_cell import lgb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_adv,
    input  t_div i_d,
    output t_div o_d
);

    t_div           r_d;
    t_div           n_d;
    logic [POS_W:0] trial;
    logic           fits;

    always_comb begin
        trial = {i_d.rem, i_d.dq[QBITS-1]};
        fits = (trial >= {1'b0, i_d.divisor});
        n_d = i_d;
        n_d.rem = fits ? POS_W'(trial - {1'b0, i_d.divisor}) : trial[POS_W-1:0];
        n_d.dq = {i_d.dq[QBITS-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else if (i_adv) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

FILE: src/lgb_rec_cell.sv
// One Bonnet recurrence step in three stages: product, combine and round, divide and saturate.
module lgb_rec_cell import lgb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic [IDX_W-1:0] i_idx,
    input  t_rec             i_r,
    output t_rec             o_r
);

    localparam int CW   = IDX_W + 2;
    localparam int P_W  = 2 * VAL_W;
    localparam int A_W  = P_W + CW + 1;
    localparam int QP_W = X_W + RECIP_S;

    t_rec                   r_r1;
    t_rec                   r_r2;
    t_rec                   r_r3;
    t_rec                   n_r3;
    logic signed [P_W-1:0]  r_prod;
    logic                   r_neg;
    logic                   r_ovf;
    logic [X_W-1:0]         r_x;

    logic [IDX_W-1:0]       idx_m1;
    logic [IDX_W-1:0]       idx_m2;
    logic signed [CW-1:0]   c_odd;
    logic signed [CW-1:0]   c_prev;
    logic signed [A_W-1:0]  a;
    logic [A_W-1:0]         amag;
    logic [A_W-1:0]         rsum;
    logic [A_W-1:0]         xfull;
    logic                   ovf;
    logic [QP_W-1:0]        qp;
    t_val                   res;

    assign idx_m1 = i_idx - IDX_W'(1);
    assign idx_m2 = i_idx - IDX_W'(2);

    // (2i-1) * u * P[i-1] - (i-1) * P[i-2] * 2^16, rounded and scaled down by 2^16.
    always_comb begin
        c_odd = $signed({1'b0, i_idx, 1'b0}) - CW'(1);
        c_prev = $signed({2'b00, i_idx}) - CW'(1);
        a = (A_W'(c_odd) * A_W'(r_prod))
            - ((A_W'(c_prev) * A_W'(r_r1.vals[idx_m2])) <<< 16);
        amag = a[A_W-1] ? A_W'(-a) : A_W'(a);
        rsum = amag + (A_W'(i_idx) << 15);
        xfull = rsum >> 16;
        ovf = (xfull >= (A_W'(i_idx) << 20));
    end

    always_comb begin
        qp = QP_W'(r_x) * QP_W'(RECIP[RECIP_IW'(i_idx)]);
        res = f_sat_mag(r_neg, r_ovf, qp[RECIP_S +: VAL_W]);
    end

    // The new Legendre value joins the ones already carried along.
    always_comb begin
        n_r3 = r_r2;
        n_r3.vals[i_idx] = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1.valid <= 1'b0;
            r_r2.valid <= 1'b0;
            r_r3.valid <= 1'b0;
        end else if (i_adv) begin
            r_r1 <= i_r;
            r_r2 <= r_r1;
            r_r3 <= n_r3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod <= i_r.u * i_r.vals[idx_m1];
            r_neg <= a[A_W-1];
            r_ovf <= ovf;
            r_x <= xfull[X_W-1:0];
        end
    end

    assign o_r = r_r3;

endmodule

FILE: src/lgb_term_gen.sv
// Serializes the products Px[p]*Py[q] of one position into output words, one per cycle while i_stall is low.
module lgb_term_gen import lgb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load_valid,
    input  t_val [MAX_ORDER:0] i_px,
    input  t_val [MAX_ORDER:0] i_py,
    input  logic [IDX_W-1:0]   i_order,
    input  logic               i_stall,
    output logic               o_take,
    output logic               o_valid,
    output logic [TERM_W-1:0]  o_index,
    output t_val               o_value,
    output logic               o_last
);

    localparam int P_W = 2 * VAL_W;

    t_val [MAX_ORDER:0]     r_px;
    t_val [MAX_ORDER:0]     r_py;
    logic [IDX_W-1:0]       r_n;
    logic [IDX_W-1:0]       r_q;
    logic [TERM_W-1:0]      r_k;
    logic                   r_busy;
    logic                   r_valid;
    logic [TERM_W-1:0]      r_index;
    t_val                   r_value;
    logic                   r_last;

    logic                   emit;
    logic                   last;
    logic                   take;
    logic [IDX_W-1:0]       p_idx;
    logic signed [P_W-1:0]  prod;
    logic [P_W:0]           pmag;
    logic [P_W:0]           psum;
    t_val                   value;

    always_comb begin
        emit = r_busy && (!r_valid || !i_stall);
        last = (r_n == i_order) && (r_q == r_n);
        take = i_load_valid && (!r_busy || (emit && last));
        p_idx = r_n - r_q;
        prod = r_px[p_idx] * r_py[r_q];
        pmag = prod[P_W-1] ? (P_W+1)'(-prod) : (P_W+1)'(prod);
        psum = pmag + (P_W+1)'(32768);
        value = f_sat_mag(prod[P_W-1], |psum[P_W:16+VAL_W], psum[16 +: VAL_W]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (take) r_busy <= 1'b1;
            else if (emit && last) r_busy <= 1'b0;
            if (emit) r_valid <= 1'b1;
            else if (!i_stall) r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_px <= i_px;
            r_py <= i_py;
            r_n <= '0;
            r_q <= '0;
            r_k <= '0;
        end else if (emit) begin
            r_k <= r_k + TERM_W'(1);
            if (r_q == r_n) begin
                r_n <= r_n + IDX_W'(1);
                r_q <= '0;
            end else begin
                r_q <= r_q + IDX_W'(1);
            end
        end
        if (emit) begin
            r_index <= r_k;
            r_value <= value;
            r_last <= last;
        end
    end

    assign o_take = take;
    assign o_valid = r_valid;
    assign o_index = r_index;
    assign o_value = r_value;
    assign o_last = r_last;

endmodule

FILE: verif/tb_top.sv
// Testbench for the 2D Legendre basis row generator: positions checked word by word.
`timescale 1ns / 100ps

module tb_top import lgb_pkg::*; ();

    localparam int LATENCY     = 30;
    localparam int CYCLE_LIMIT = 400000;

    // One expected output word of a basis row.
    typedef struct {
        logic [TERM_W-1:0] index;
        t_val              value;
        logic              last;
    } t_term;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 i_valid;
    logic                 o_stall;
    logic [POS_W-1:0]     i_pos_x;
    logic [POS_W-1:0]     i_pos_y;
    logic                 o_valid;
    logic                 i_stall;
    logic [TERM_W-1:0]    o_term_index;
    logic signed [VAL_W-1:0] o_term_value;
    logic                 o_last_term;

    // Shadow copy of the configuration registers, used by the predictor.
    logic [ORD_W-1:0] cfg_order;
    logic [POS_W-1:0] cfg_x_lo, cfg_x_hi, cfg_y_lo, cfg_y_hi;

    t_term expected_terms[$];
    int    error_count;
    int    cycle_count;
    int    stall_mode;

    legendre_2d_basis_row_top i_dut (.*);

    // The clock runs at a 12 ns period.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // A watchdog ends the run as failed once the cycle count passes CYCLE_LIMIT.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Rounds n/d to nearest with ties away from zero; d is positive.
    function automatic longint round_div(longint n, longint d);
        if (n >= 0) return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic longint clamp_q316(longint v);
        if (v > 524287) return 524287;
        if (v < -524288) return -524288;
        return v;
    endfunction

    // Legendre values P0..Pn of one coordinate after it is mapped onto [-1,1].
    function automatic void legendre_values(input logic [POS_W-1:0] pos, lo, hi,
                                            input int order, output longint vals[MAX_ORDER+1]);
        longint span, u, a, b;
        span = longint'(hi) - longint'(lo);
        u = 0;
        if (span > 0)
            u = clamp_q316(round_div((2 * longint'(pos) - lo - hi) * 65536, span));
        vals[0] = 65536;
        for (int i = 1; i <= MAX_ORDER; i++) vals[i] = 0;
        if (order > 0) vals[1] = u;
        for (int i = 2; i <= order; i++) begin
            a = longint'(2 * i - 1) * u * vals[i-1];
            b = longint'(i - 1) * vals[i-2] * 65536;
            vals[i] = clamp_q316(round_div(a - b, longint'(i) * 65536));
        end
    endfunction

    // Queues the whole basis row that one position should produce.
    task automatic predict_basis_row(input logic [POS_W-1:0] x, y);
        longint px[MAX_ORDER+1];
        longint py[MAX_ORDER+1];
        int     order, total, k;
        t_term  t;
        order = (cfg_order > MAX_ORDER) ? MAX_ORDER : int'(cfg_order);
        total = (order + 1) * (order + 2) / 2;
        legendre_values(x, cfg_x_lo, cfg_x_hi, order, px);
        legendre_values(y, cfg_y_lo, cfg_y_hi, order, py);
        k = 0;
        for (int n = 0; n <= order; n++) begin
            for (int q = 0; q <= n; q++) begin
                t.index = TERM_W'(k);
                t.value = t_val'(clamp_q316(round_div(px[n-q] * py[q], 65536)));
                t.last  = (k + 1 == total);
                expected_terms.insert(expected_terms.size(), t);
                k++;
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // The receiver stalls on a pattern chosen per phase: none, light, heavy or bursty.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                2: i_stall <= ($urandom_range(0, 3) != 0);
                default: i_stall <= (cycle_count % 16) < 5;
            endcase
        end
    end

    // Each accepted word is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_term t;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_terms.size() == 0) begin
                report_mismatch($sformatf("unexpected word index %0d", o_term_index));
            end else begin
                t = expected_terms.pop_front();
                if (o_term_index !== t.index)
                    report_mismatch($sformatf("index %0d, want %0d", o_term_index, t.index));
                if (o_term_value !== t.value)
                    report_mismatch($sformatf("value %0d, want %0d (index %0d)",
                                              o_term_value, t.value, t.index));
                if (o_last_term !== t.last)
                    report_mismatch($sformatf("last %0b, want %0b (index %0d)",
                                              o_last_term, t.last, t.index));
            end
        end
    end

    // Writes one register through the setup and access phases.
    task automatic write_register(input logic [2:0] index, input logic [DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({index, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_FIT_ORDER: cfg_order = value[ORD_W-1:0];
            REG_X_LOW:     cfg_x_lo  = value[POS_W-1:0];
            REG_X_HIGH:    cfg_x_hi  = value[POS_W-1:0];
            REG_Y_LOW:     cfg_y_lo  = value[POS_W-1:0];
            REG_Y_HIGH:    cfg_y_hi  = value[POS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_region(input logic [2:0] order, input logic [POS_W-1:0] xl, xh, yl, yh);
        write_register(REG_FIT_ORDER, DATA_W'(order));
        write_register(REG_X_LOW, DATA_W'(xl));
        write_register(REG_X_HIGH, DATA_W'(xh));
        write_register(REG_Y_LOW, DATA_W'(yl));
        write_register(REG_Y_HIGH, DATA_W'(yh));
    endtask

    // Sends one position word, holding valid until the block takes it.
    task automatic send_position(input logic [POS_W-1:0] x, y);
        i_valid <= 1'b1;
        i_pos_x <= x;
        i_pos_y <= y;
        do @(posedge i_clk); while (o_stall);
        predict_basis_row(x, y);
    endtask

    task automatic idle_sender(input int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Waits until every expected word has arrived, then lets the pipeline drain.
    task automatic drain_block();
        i_valid <= 1'b0;
        while (expected_terms.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    // Sends a burst-shaped stream of random positions, some near the bounds.
    task automatic send_random_positions(input int count);
        int burst;
        logic [POS_W-1:0] x, y;
        burst = $urandom_range(1, 8);
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 3))
                0: begin
                    x = POS_W'($urandom);
                    y = POS_W'($urandom);
                end
                1: begin
                    x = cfg_x_lo + POS_W'($urandom_range(0, 31));
                    y = cfg_y_hi - POS_W'($urandom_range(0, 31));
                end
                default: begin
                    x = ($urandom_range(0, 1) && cfg_x_hi > cfg_x_lo) ?
                        POS_W'($urandom_range(cfg_x_lo, cfg_x_hi)) : POS_W'($urandom);
                    y = (cfg_y_hi > cfg_y_lo) ?
                        POS_W'($urandom_range(cfg_y_lo, cfg_y_hi)) : POS_W'($urandom);
                end
            endcase
            send_position(x, y);
            if (--burst == 0) begin
                idle_sender($urandom_range(1, 20));
                burst = $urandom_range(1, 8);
            end
        end
    endtask

    // Extremes of the positions with the reset region and at the top order.
    task automatic test_directed_extremes();
        stall_mode = 0;
        send_position(16'h0000, 16'h0000);
        send_position(16'hFFFF, 16'hFFFF);
        send_position(16'h0000, 16'hFFFF);
        send_position(16'h7FFF, 16'h8000);
        send_position(16'hAAAA, 16'h5555);
        drain_block();
        set_region(3'd4, 16'd1000, 16'd3000, 16'd0, 16'd65535);
        send_position(16'd2000, 16'd32767);
        send_position(16'd1000, 16'd0);
        send_position(16'd3000, 16'd65535);
        send_position(16'd1500, 16'd16384);
        send_position(16'd2500, 16'd49151);
        drain_block();
    endtask

    // Positions far outside the region drive the values into saturation.
    task automatic test_outside_bounds();
        stall_mode = 1;
        set_region(3'd4, 16'd30000, 16'd30004, 16'd100, 16'd101);
        send_position(16'hFFFF, 16'h0000);
        send_position(16'h0000, 16'hFFFF);
        send_position(16'd30002, 16'd100);
        send_position(16'd30005, 16'd102);
        drain_block();
    endtask

    // An empty or inverted span gives a normalized coordinate of zero.
    task automatic test_degenerate_spans();
        stall_mode = 3;
        set_region(3'd3, 16'd500, 16'd500, 16'd9000, 16'd8000);
        send_position(16'd0, 16'hFFFF);
        send_position(16'd500, 16'd8500);
        drain_block();
    endtask

    // Every order, including those above the built maximum.
    task automatic test_all_orders();
        stall_mode = 1;
        for (int o = 0; o < 8; o++) begin
            set_region(3'(o), 16'd0, 16'hFFFF, 16'd4096, 16'd61440);
            send_position(POS_W'($urandom), POS_W'($urandom));
            drain_block();
        end
    endtask

    // Random positions across several region settings and stall patterns.
    task automatic test_random_regions();
        logic [POS_W-1:0] a, b;
        for (int phase = 0; phase < 8; phase++) begin
            stall_mode = phase % 4;
            a = POS_W'($urandom);
            b = POS_W'($urandom);
            if (phase == 0)
                set_region(3'd4, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
            else if (phase == 1)
                set_region(3'd0, 16'hFFFF, 16'd0, 16'hFFFE, 16'hFFFF);
            else
                set_region(3'($urandom_range(0, 7)), (a < b) ? a : b, (a < b) ? b : a,
                           POS_W'($urandom_range(0, 30000)),
                           POS_W'($urandom_range(30001, 65535)));
            send_random_positions(48);
            // Let everything drain once mid-phase before carrying on.
            if (phase == 3) begin
                i_valid <= 1'b0;
                while (expected_terms.size() != 0) @(posedge i_clk);
                @(posedge i_clk);
            end
            drain_block();
        end
    endtask

    initial begin
        error_count = 0;
        cycle_count = 0;
        stall_mode  = 0;
        i_rst_n = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        i_valid = 1'b0;
        i_pos_x = '0;
        i_pos_y = '0;
        cfg_order = 3'd2;
        cfg_x_lo  = 16'd0;
        cfg_x_hi  = 16'hFFFF;
        cfg_y_lo  = 16'd0;
        cfg_y_hi  = 16'hFFFF;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_outside_bounds();
        test_degenerate_spans();
        test_all_orders();
        test_random_regions();

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/lgb_pkg.sv
src/lgb_div_cell.sv
src/lgb_rec_cell.sv
src/lgb_term_gen.sv
src/legendre_2d_basis_row_top.sv
verif/tb_top.sv
